// ===== design/open_address_hash_table_assert.svh =====
// Assertion macros for the open address hash table RTL.
// Included by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`ifndef SYNTH
// Check an implication or a plain condition on every clock outside reset
`define OHASH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: lbl");
// Check that a condition leads to another one on the next clock
`define OHASH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: lbl");
`else
`define OHASH_ASSERT(lbl, prop)
`define OHASH_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== design/ohash_pkg.sv =====
// Shared types and constants of the open address hash table.
// No dependencies; imported by every module of the block but ohash_ram.
package ohash_pkg;

  localparam int TABLE_DEPTH_I = 256;
  localparam int SLOT_W = $clog2(TABLE_DEPTH_I);
  localparam int SIZE_W = SLOT_W + 1;
  localparam int KEY_W = 23;
  localparam int TAG_W = 32;
  localparam int COLL_W = 16;
  localparam int FRAC_W = 24;
  localparam int SUM_W = 15;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [SIZE_W-1:0] TABLE_DEPTH = SIZE_W'(TABLE_DEPTH_I);
  // 0.414141 in unsigned Q0.24, rounded to nearest
  localparam logic [22:0] HASH_K = 23'd6948133;
  localparam logic [COLL_W-1:0] COLL_MAX = '1;

  // Request actions
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Classified request, front to back
  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] home;
    logic [SIZE_W-1:0] n;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  record;
    logic [SIZE_W-1:0] steps;
    logic [COLL_W-1:0] coll;
  } res_t;

endpackage

// ===== design/open_address_hash_table.sv =====
// Open address hash table keyed by date, linear probing, up to 256 slots.
// Request channel: in_valid/in_ready with action, day, month, year, record_tag.
//   Actions: clear, insert (store tag under the date), look up by date.
// Result channel: out_valid/out_ready with status, slot, record_out,
//   probe_steps and total_collisions; exactly one result per request.
// Configuration: cfg_we/cfg_wdata writes table_size (0 acts as 1, above 256
//   as 256); write it only while no request is in flight.
// The table engine handles one request at a time; an insert or a lookup walks
//   the valid bits and the key/record RAM one slot per cycle. A hash stage and
//   a two-entry queue keep taking requests while the engine walks.
// Reset empties the table, zeroes the collision count and sets table_size
//   to 256. When out_ready is low the result is held in the output register;
//   the engine stops after its next result and requests back up into the
//   queue until in_ready drops.
module open_address_hash_table import ohash_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [4:0]        day,
  input  logic [3:0]        month,
  input  logic [13:0]       year,
  input  logic [TAG_W-1:0]  record_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [SLOT_W-1:0] slot,
  output logic [TAG_W-1:0]  record_out,
  output logic [SIZE_W-1:0] probe_steps,
  output logic [COLL_W-1:0] total_collisions
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;
  res_t out_res;

  ohash_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .day       (day),
    .month     (month),
    .year      (year),
    .record_tag(record_tag),
    .push      (push),
    .cmd       (push_cmd),
    .q_full    (q_full)
  );

  ohash_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  ohash_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (q_head),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  // Spread the result over the output ports
  assign status           = out_res.status;
  assign slot             = out_res.slot;
  assign record_out       = out_res.record;
  assign probe_steps      = out_res.steps;
  assign total_collisions = out_res.coll;

endmodule

// ===== design/ohash_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ohash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ohash_front.sv =====
// Front end: table size register, request intake and home slot hashing.
// Depends on ohash_pkg; feeds ohash_queue with cmd_t requests.
module ohash_front import ohash_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [4:0]        day,
  input  logic [3:0]        month,
  input  logic [13:0]       year,
  input  logic [TAG_W-1:0]  record_tag,
  output logic              push,
  output cmd_t              cmd,
  input  logic              q_full
);

  logic [SIZE_W-1:0]         table_size;
  logic [SIZE_W-1:0]         eff_n;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W+22:0]         prod;
  logic                      a_valid;
  logic [FRAC_W-1:0]         a_frac;
  logic [1:0]                a_action;
  logic [KEY_W-1:0]          a_key;
  logic [TAG_W-1:0]          a_tag;
  logic [SIZE_W-1:0]         a_n;
  logic [FRAC_W+SIZE_W-1:0]  home_prod;
  logic                      accept;

  // Hold the table size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_DEPTH;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // Clamp size into the usable range
  always_comb begin
    eff_n = table_size;
    if (table_size == '0) begin
      eff_n = SIZE_W'(1);
    end else if (table_size > TABLE_DEPTH) begin
      eff_n = TABLE_DEPTH;
    end
  end

  // First hash step: fraction of the date sum times the constant
  assign sum  = SUM_W'(day) + SUM_W'(month) + SUM_W'(year);
  assign prod = (SUM_W+23)'(sum) * (SUM_W+23)'(HASH_K);

  assign push     = a_valid && !q_full;
  assign in_ready = !a_valid || !q_full;
  assign accept   = in_valid && in_ready;

  // Advance the hash stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_frac   <= prod[FRAC_W-1:0];
      a_action <= action;
      a_key    <= {day, month, year};
      a_tag    <= record_tag;
      a_n      <= eff_n;
    end
  end

  // Second hash step: scale fraction by the size and floor
  assign home_prod = (FRAC_W+SIZE_W)'(a_frac) * (FRAC_W+SIZE_W)'(a_n);

  always_comb begin
    cmd.action = a_action;
    cmd.key    = a_key;
    cmd.tag    = a_tag;
    cmd.home   = home_prod[FRAC_W+SLOT_W-1:FRAC_W];
    cmd.n      = a_n;
  end

endmodule

// ===== design/ohash_queue.sv =====
// Two-entry request queue between the front end and the table engine.
// Depends on ohash_pkg and the assertion macro header.
`include "open_address_hash_table_assert.svh"
module ohash_queue import ohash_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

  `OHASH_ASSERT(a_no_overflow, push |-> !full)
  `OHASH_ASSERT(a_no_underflow, pop |-> not_empty)

endmodule

// ===== design/ohash_back.sv =====
// Table engine: valid bits, key/record RAM, probe walks and result register.
// Depends on ohash_pkg, ohash_ram and the assertion macro header.
`include "open_address_hash_table_assert.svh"
module ohash_back import ohash_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_LKP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                   state;
  cmd_t                     cur;
  logic [SLOT_W-1:0]        pos;
  logic [SLOT_W-1:0]        pos_next;
  logic [SIZE_W-1:0]        cnt;
  logic [TABLE_DEPTH_I-1:0] slot_valid;
  logic [COLL_W-1:0]        coll;
  logic [COLL_W:0]          coll_sum;
  logic [COLL_W-1:0]        coll_sat;
  res_t                     res;
  logic                     p_live;
  logic [SLOT_W-1:0]        p_pos;
  logic [SIZE_W-1:0]        p_i;
  logic                     p_vld;
  logic                     issuing;
  logic                     fin_load;
  logic                     ram_we;
  logic [KEY_W+TAG_W-1:0]   ram_rdata;

  // Step the probe position with wrap at the table size
  assign pos_next = ((SIZE_W'(pos) + 1'b1) == cur.n) ? '0 : pos + 1'b1;

  // Saturating collision total after this insert
  assign coll_sum = (COLL_W+1)'(coll) + (COLL_W+1)'(cnt);
  assign coll_sat = coll_sum[COLL_W] ? COLL_MAX : coll_sum[COLL_W-1:0];

  assign pop      = (state == S_IDLE) && q_valid;
  assign ram_we   = (state == S_INS) && !slot_valid[pos];
  assign issuing  = (state == S_LKP) && (cnt != cur.n);
  assign fin_load = (state == S_FIN) && (!out_valid || out_ready);

  ohash_ram #(
    .WIDTH(KEY_W + TAG_W),
    .DEPTH(TABLE_DEPTH_I)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos),
    .wdata({cur.key, cur.tag}),
    .raddr(pos),
    .rdata(ram_rdata)
  );

  // Sequence requests through the table
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      coll       <= '0;
      p_live     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur    <= head;
            pos    <= head.home;
            cnt    <= '0;
            p_live <= 1'b0;
            case (head.action)
              ACT_CLEAR: begin
                slot_valid <= '0;
                coll       <= '0;
                res        <= '0;
                state      <= S_FIN;
              end
              ACT_INSERT: begin
                state <= S_INS;
              end
              ACT_LOOKUP: begin
                state <= S_LKP;
              end
              default: begin
                res   <= {ST_OK, SLOT_W'(0), TAG_W'(0), SIZE_W'(0), coll};
                state <= S_FIN;
              end
            endcase
          end
        end
        S_INS: begin
          if (!slot_valid[pos]) begin
            slot_valid[pos] <= 1'b1;
            coll            <= coll_sat;
            res.status      <= ST_OK;
            res.slot        <= pos;
            res.record      <= '0;
            res.steps       <= cnt;
            res.coll        <= coll_sat;
            state           <= S_FIN;
          end else if (cnt == cur.n - 1'b1) begin
            res.status <= ST_FULL;
            res.slot   <= '0;
            res.record <= '0;
            res.steps  <= cnt;
            res.coll   <= coll;
            state      <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
            pos <= pos_next;
          end
        end
        S_LKP: begin
          // Issue one slot read per cycle
          p_live <= issuing;
          p_pos  <= pos;
          p_i    <= cnt;
          p_vld  <= slot_valid[pos];
          if (issuing) begin
            cnt <= cnt + 1'b1;
            pos <= pos_next;
          end
          // Compare the slot read last cycle
          if (p_live) begin
            if (p_vld && (ram_rdata[KEY_W+TAG_W-1:TAG_W] == cur.key)) begin
              res.status <= ST_OK;
              res.slot   <= p_pos;
              res.record <= ram_rdata[TAG_W-1:0];
              res.steps  <= p_i;
              res.coll   <= coll;
              state      <= S_FIN;
            end else if (p_i == cur.n - 1'b1) begin
              res.status <= ST_MISS;
              res.slot   <= '0;
              res.record <= '0;
              res.steps  <= cur.n;
              res.coll   <= coll;
              state      <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_res <= res;
    end
  end

  `OHASH_ASSERT(a_write_only_on_insert, ram_we |-> (state == S_INS))
  `OHASH_ASSERT(a_probe_in_range, (state == S_INS || state == S_LKP) |-> (SIZE_W'(pos) < cur.n))
  `OHASH_ASSERT_NEXT(a_result_held, (state == S_FIN) && out_valid && !out_ready, state == S_FIN)

endmodule
